// ===== hw/rtl/u8tc_pkg.sv =====
// Shared types and constants of the UTF-16/UTF-32 to UTF-8 transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u8tc_pkg;

	localparam logic [2:0] ENC_RAW   = 3'd0;
	localparam logic [2:0] ENC_UTF8  = 3'd1;
	localparam logic [2:0] ENC_U16LE = 3'd2;
	localparam logic [2:0] ENC_U16BE = 3'd3;
	localparam logic [2:0] ENC_U32LE = 3'd4;
	localparam logic [2:0] ENC_U32BE = 3'd5;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_BAD_LEAD = 2'd1;
	localparam logic [1:0] ERR_TOO_BIG  = 2'd2;

	localparam logic [31:0] CODE_2BYTE_MIN = 32'h0000_0080;
	localparam logic [31:0] CODE_3BYTE_MIN = 32'h0000_0800;
	localparam logic [31:0] CODE_TOO_BIG   = 32'h0001_0000;

	// One queued job: either a finished single result or a code point to expand.
	typedef struct packed {
		logic        is_code;
		logic [15:0] code;
		logic [7:0]  data;
		logic        char_end;
		logic [1:0]  err;
	} job_t;

	// Character length from a UTF-8 lead byte; zero for an invalid lead.
	function automatic logic [2:0] lead_size(input logic [7:0] b);
		logic [2:0] n;
		begin
			if (b[7] == 1'b0)              n = 3'd1;
			else if (b[7:5] == 3'b110)     n = 3'd2;
			else if (b[7:4] == 4'b1110)    n = 3'd3;
			else if (b[7:3] == 5'b11110)   n = 3'd4;
			else if (b[7:2] == 6'b111110)  n = 3'd5;
			else if (b[7:1] == 7'b1111110) n = 3'd6;
			else                           n = 3'd0;
			return n;
		end
	endfunction

endpackage

// ===== hw/rtl/utf16_utf32_to_utf8_transcoder_core.sv =====
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
// Instantiates u8tc_front, u8tc_queue and u8tc_back; uses u8tc_pkg.
//
// Converts a byte stream in raw, UTF-8, UTF-16 LE/BE or UTF-32 LE/BE (set by
// a cfg_we/cfg_data write that the user must make only while idle; the block
// does not enforce this) into UTF-8 result items. One input byte is taken
// every cycle while the job queue has room; each byte yields zero results
// (partial code unit) or one job, and the back end emits one result item per
// cycle while out_stall is low, so a code point gives 1 to 3 result items.
// The output port thus sets the sustained rate, as a two-byte UTF-16 unit can
// give three result bytes. Code points of 0x10000 and above give an error
// item; surrogates are not combined; only reset drops a partial character.
module utf16_utf32_to_utf8_transcoder_core #(
	parameter int QueueDepth = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       char_end,
	output logic [1:0] error_kind
);

	logic           push_valid;
	u8tc_pkg::job_t push_job;
	logic           queue_full;
	logic           pop;
	logic           head_valid;
	u8tc_pkg::job_t head_job;

	u8tc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.in_stall   (in_stall),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	u8tc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	u8tc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.char_end   (char_end),
		.error_kind (error_kind)
	);

endmodule

// ===== hw/rtl/u8tc_front.sv =====
// Front part of the transcoder: holds the encoding register, accepts input
// items, gathers code units and classifies each into a job. Uses u8tc_pkg.
module u8tc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_data,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	output logic               in_stall,
	input  logic               queue_full,
	output logic               push_valid,
	output u8tc_pkg::job_t     push_job
);

	logic [2:0]  enc_q;
	logic [31:0] acc_q;
	logic [1:0]  gathered_q;
	logic [2:0]  remaining_q;

	logic [31:0] acc_d;
	logic [1:0]  gathered_d;
	logic [2:0]  remaining_d;
	logic        emit;
	logic        accept;
	logic        little;
	logic        wide;
	logic        done;
	logic [2:0]  lsize;
	logic [31:0] acc_new;
	logic [31:0] code;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign push_valid = accept && emit;

	always_comb begin
		acc_d       = acc_q;
		gathered_d  = gathered_q;
		remaining_d = remaining_q;
		emit        = 1'b1;
		push_job    = '0;
		little      = (enc_q == u8tc_pkg::ENC_U16LE) || (enc_q == u8tc_pkg::ENC_U32LE);
		wide        = (enc_q == u8tc_pkg::ENC_U32LE) || (enc_q == u8tc_pkg::ENC_U32BE);
		lsize       = u8tc_pkg::lead_size(in_byte);
		acc_new     = little ? (acc_q | ({24'd0, in_byte} << {gathered_q, 3'b000}))
			: {acc_q[23:0], in_byte};
		done        = wide ? (gathered_q == 2'd3) : (gathered_q != 2'd0);
		code        = wide ? acc_new : {16'd0, acc_new[15:0]};
		case (enc_q)
			u8tc_pkg::ENC_UTF8: begin
				if (remaining_q != 3'd0) begin
					remaining_d       = remaining_q - 3'd1;
					push_job.data     = in_byte;
					push_job.char_end = (remaining_q == 3'd1);
					push_job.err      = u8tc_pkg::ERR_NONE;
				end else if (lsize == 3'd0) begin
					push_job.data     = 8'd0;
					push_job.char_end = 1'b1;
					push_job.err      = u8tc_pkg::ERR_BAD_LEAD;
				end else begin
					remaining_d       = lsize - 3'd1;
					push_job.data     = in_byte;
					push_job.char_end = (lsize == 3'd1);
					push_job.err      = u8tc_pkg::ERR_NONE;
				end
			end
			u8tc_pkg::ENC_U16LE, u8tc_pkg::ENC_U16BE,
			u8tc_pkg::ENC_U32LE, u8tc_pkg::ENC_U32BE: begin
				if (!done) begin
					acc_d      = acc_new;
					gathered_d = gathered_q + 2'd1;
					emit       = 1'b0;
				end else begin
					acc_d      = '0;
					gathered_d = '0;
					if (code >= u8tc_pkg::CODE_TOO_BIG) begin
						push_job.data     = 8'd0;
						push_job.char_end = 1'b1;
						push_job.err      = u8tc_pkg::ERR_TOO_BIG;
					end else begin
						push_job.is_code  = 1'b1;
						push_job.code     = code[15:0];
						push_job.char_end = 1'b1;
						push_job.err      = u8tc_pkg::ERR_NONE;
					end
				end
			end
			default: begin
				push_job.data     = in_byte;
				push_job.char_end = 1'b1;
				push_job.err      = u8tc_pkg::ERR_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q       <= u8tc_pkg::ENC_RAW;
			acc_q       <= '0;
			gathered_q  <= '0;
			remaining_q <= '0;
		end else begin
			if (cfg_we) begin
				enc_q <= cfg_data;
			end
			if (accept) begin
				acc_q       <= acc_d;
				gathered_q  <= gathered_d;
				remaining_q <= remaining_d;
			end
		end
	end

endmodule

// ===== hw/rtl/u8tc_queue.sv =====
// Short job queue between the front and back parts of the transcoder.
// Register-based; uses the job type from u8tc_pkg.
module u8tc_queue #(
	parameter int Depth = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u8tc_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output u8tc_pkg::job_t head_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	u8tc_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/u8tc_back.sv =====
// Back part of the transcoder: expands queued jobs into UTF-8 result items,
// one per cycle while out_stall is low, through an output register. Uses u8tc_pkg.
module u8tc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  u8tc_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           char_end,
	output logic [1:0]     error_kind
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       char_end_q;
	logic [1:0] error_kind_q;
	logic [1:0] idx_q;

	logic       load;
	logic [1:0] last_idx;
	logic       last;
	logic [7:0] next_byte;
	logic       next_end;
	logic [1:0] next_err;
	logic [31:0] code32;

	assign code32 = {16'd0, head_job.code};
	assign load   = head_valid && (!out_valid_q || !out_stall);
	assign last   = (idx_q == last_idx);
	assign pop    = load && last;

	always_comb begin
		if (!head_job.is_code || code32 < u8tc_pkg::CODE_2BYTE_MIN) begin
			last_idx = 2'd0;
		end else if (code32 < u8tc_pkg::CODE_3BYTE_MIN) begin
			last_idx = 2'd1;
		end else begin
			last_idx = 2'd2;
		end
		next_err = head_job.err;
		next_end = last && head_job.char_end;
		if (!head_job.is_code) begin
			next_byte = head_job.data;
		end else begin
			case (last_idx)
				2'd0: next_byte = head_job.code[7:0];
				2'd1: next_byte = (idx_q == 2'd0) ? {3'b110, head_job.code[10:6]}
					: {2'b10, head_job.code[5:0]};
				default: begin
					case (idx_q)
						2'd0:    next_byte = {4'b1110, head_job.code[15:12]};
						2'd1:    next_byte = {2'b10, head_job.code[11:6]};
						default: next_byte = {2'b10, head_job.code[5:0]};
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= next_byte;
			char_end_q   <= next_end;
			error_kind_q <= next_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign char_end   = char_end_q;
	assign error_kind = error_kind_q;

endmodule

// ===== tb/tb_utf16_utf32_to_utf8_transcoder_core.sv =====
// Self-checking testbench of utf16_utf32_to_utf8_transcoder_core: random byte streams in
// every source encoding, predicted by a scoreboard class and compared item by item.
// Depends on u8tc_pkg and the transcoder RTL only.

typedef struct packed {
	logic [7:0] data;
	logic       last;
	logic [1:0] err;
} utf8_item_t;

class utf8_scoreboard;
	logic [2:0]  encoding;
	logic [31:0] unit_acc;
	logic [2:0]  unit_bytes;
	logic [2:0]  cont_left;
	utf8_item_t  expected_q[$];
	int          mismatches;
	int          checked;

	function new();
		encoding   = u8tc_pkg::ENC_RAW;
		unit_acc   = '0;
		unit_bytes = '0;
		cont_left  = '0;
		mismatches = 0;
		checked    = 0;
	endfunction

	function void set_encoding(logic [2:0] e);
		encoding = e;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function logic [2:0] lead_length(logic [7:0] b);
		casez (b)
			8'b0???????: return 3'd1;
			8'b110?????: return 3'd2;
			8'b1110????: return 3'd3;
			8'b11110???: return 3'd4;
			8'b111110??: return 3'd5;
			8'b1111110?: return 3'd6;
			default:     return 3'd0;
		endcase
	endfunction

	function void push(logic [7:0] d, logic l, logic [1:0] k);
		utf8_item_t it;
		it.data = d;
		it.last = l;
		it.err  = k;
		expected_q.push_back(it);
	endfunction

	function void note_input(logic [7:0] b);
		logic [2:0]  n;
		logic [31:0] code;
		int          unit_len;
		bit          little;
		logic [1:0]  g;
		if (encoding == u8tc_pkg::ENC_UTF8) begin
			if (cont_left != 3'd0) begin
				cont_left = cont_left - 3'd1;
				push(b, cont_left == 3'd0, u8tc_pkg::ERR_NONE);
			end else begin
				n = lead_length(b);
				if (n == 3'd0) begin
					push(8'h00, 1'b1, u8tc_pkg::ERR_BAD_LEAD);
				end else begin
					cont_left = n - 3'd1;
					push(b, n == 3'd1, u8tc_pkg::ERR_NONE);
				end
			end
			return;
		end
		if (encoding < u8tc_pkg::ENC_U16LE || encoding > u8tc_pkg::ENC_U32BE) begin
			push(b, 1'b1, u8tc_pkg::ERR_NONE);
			return;
		end
		unit_len = (encoding <= u8tc_pkg::ENC_U16BE) ? 2 : 4;
		little = (encoding == u8tc_pkg::ENC_U16LE) || (encoding == u8tc_pkg::ENC_U32LE);
		g = unit_bytes[1:0];
		if (little)
			unit_acc = unit_acc | ({24'h0, b} << (8 * g));
		else
			unit_acc = {unit_acc[23:0], b};
		if (int'(unit_bytes) + 1 < unit_len) begin
			unit_bytes = unit_bytes + 3'd1;
			return;
		end
		code = unit_acc;
		if (unit_len == 2)
			code = code & 32'h0000_ffff;
		unit_acc   = '0;
		unit_bytes = '0;
		if (code < u8tc_pkg::CODE_2BYTE_MIN) begin
			push(code[7:0], 1'b1, u8tc_pkg::ERR_NONE);
		end else if (code < u8tc_pkg::CODE_3BYTE_MIN) begin
			push({3'b110, code[10:6]}, 1'b0, u8tc_pkg::ERR_NONE);
			push({2'b10, code[5:0]}, 1'b1, u8tc_pkg::ERR_NONE);
		end else if (code < u8tc_pkg::CODE_TOO_BIG) begin
			push({4'b1110, code[15:12]}, 1'b0, u8tc_pkg::ERR_NONE);
			push({2'b10, code[11:6]}, 1'b0, u8tc_pkg::ERR_NONE);
			push({2'b10, code[5:0]}, 1'b1, u8tc_pkg::ERR_NONE);
		end else begin
			push(8'h00, 1'b1, u8tc_pkg::ERR_TOO_BIG);
		end
	endfunction

	function void check_result(logic [7:0] d, logic l, logic [1:0] k);
		utf8_item_t want;
		checked++;
		if (expected_q.size() == 0) begin
			if (mismatches < 10)
				$display("MISMATCH: unexpected item byte=%02h end=%0b err=%0d", d, l, k);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		if (want.data !== d || want.last !== l || want.err !== k) begin
			if (mismatches < 10)
				$display("MISMATCH: expected byte=%02h end=%0b err=%0d, got byte=%02h end=%0b err=%0d",
					want.data, want.last, want.err, d, l, k);
			mismatches++;
		end
	endfunction
endclass

module tb_utf16_utf32_to_utf8_transcoder_core;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       char_end;
	logic [1:0] error_kind;

	utf8_scoreboard sb;
	int sent_items = 0;
	int phases = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	utf16_utf32_to_utf8_transcoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.char_end  (char_end),
		.error_kind(error_kind)
	);

	always #1 clk = ~clk;

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return $urandom_range(1, 3);
		if (r < 18) return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_code(bit wide);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2: return $urandom_range(0, 'h7f);
			3, 4:    return $urandom_range('h80, 'h7ff);
			5, 6:    return $urandom_range('h800, 'hffff);
			7:       return $urandom_range('hd800, 'hdfff);
			8: begin
				case ($urandom_range(0, 6))
					0: return 32'h0000_0000;
					1: return 32'h0000_007f;
					2: return 32'h0000_0080;
					3: return 32'h0000_07ff;
					4: return 32'h0000_0800;
					5: return 32'h0000_ffff;
					default: return wide ? 32'h0001_0000 : 32'h0000_ffff;
				endcase
			end
			default: return wide ? $urandom : $urandom_range(0, 'hffff);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_length();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sb.note_input(b);
		sent_items++;
	endtask

	task automatic send_unit(input logic [31:0] code, input int len, input bit little);
		for (int i = 0; i < len; i++) begin
			if (little)
				send_byte(code[8 * i +: 8]);
			else
				send_byte(code[8 * (len - 1 - i) +: 8]);
		end
	endtask

	task automatic send_utf8_char();
		int len;
		int cont;
		logic [7:0] r;
		r = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			send_byte(r);
			return;
		end
		len = $urandom_range(1, 6);
		case (len)
			1: send_byte({1'b0, r[6:0]});
			2: send_byte({3'b110, r[4:0]});
			3: send_byte({4'b1110, r[3:0]});
			4: send_byte({5'b11110, r[2:0]});
			5: send_byte({6'b111110, r[1:0]});
			default: send_byte({7'b1111110, r[0]});
		endcase
		cont = len - 1;
		if (cont > 0 && $urandom_range(0, 9) == 0)
			cont = $urandom_range(0, cont - 1);
		repeat (cont) begin
			r = 8'($urandom_range(0, 255));
			send_byte({2'b10, r[5:0]});
		end
	endtask

	task automatic send_char(input logic [2:0] enc);
		case (enc)
			u8tc_pkg::ENC_UTF8: send_utf8_char();
			u8tc_pkg::ENC_U16LE, u8tc_pkg::ENC_U16BE,
			u8tc_pkg::ENC_U32LE, u8tc_pkg::ENC_U32BE: begin
				if ($urandom_range(0, 14) == 0)
					send_byte(8'($urandom_range(0, 255)));
				else if (enc <= u8tc_pkg::ENC_U16BE)
					send_unit(pick_code(1'b0), 2, enc == u8tc_pkg::ENC_U16LE);
				else
					send_unit(pick_code(1'b1), 4, enc == u8tc_pkg::ENC_U32LE);
			end
			default: send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic finish_phase();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		phases++;
	endtask

	task automatic write_encoding(input logic [2:0] e);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= e;
		@(negedge clk) cfg_we <= 1'b0;
		sb.set_encoding(e);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, char_end, error_kind);
	end

	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 100;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 2) == 0)
					stall_left = gap_length();
			end
		end
	end

	initial begin
		#2000000;
		$display("utf16_utf32_to_utf8_transcoder_core verification failed");
		$finish;
	end

	initial begin
		int target;
		int p;
		logic [2:0] enc;
		sb       = new();
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_byte  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send_byte(8'h00);
		send_byte(8'hff);
		finish_phase();
		write_encoding(u8tc_pkg::ENC_UTF8);
		send_byte(8'h7f);
		send_byte(8'hc2);
		send_byte(8'h80);
		send_byte(8'hfe);
		send_byte(8'hff);
		send_byte(8'hfd);
		repeat (5) send_byte(8'hbf);
		finish_phase();
		write_encoding(u8tc_pkg::ENC_U16LE);
		send_unit(32'h0000_007f, 2, 1'b1);
		send_unit(32'h0000_07ff, 2, 1'b1);
		finish_phase();
		write_encoding(u8tc_pkg::ENC_U16BE);
		send_unit(32'h0000_ffff, 2, 1'b0);
		send_unit(32'h0000_d800, 2, 1'b0);
		finish_phase();
		write_encoding(u8tc_pkg::ENC_U32LE);
		send_unit(32'h0001_0000, 4, 1'b1);
		finish_phase();
		write_encoding(u8tc_pkg::ENC_U32BE);
		send_unit(32'h0000_0080, 4, 1'b0);
		finish_phase();

		p = 0;
		while (sent_items < 525) begin
			enc  = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
			calm = (p % 6 == 5) || (p == 3);
			write_encoding(enc);
			if (p == 3)
				hold_req = 1'b1;
			target = sent_items + $urandom_range(20, 45);
			while (sent_items < target)
				send_char(enc);
			finish_phase();
			p++;
		end
		calm = 1'b0;
		repeat (10) @(posedge clk);

		$display("Covered %0d input items and %0d result items over %0d phases,",
			sent_items, sb.checked, phases);
		$display("all eight encoding codes, both error kinds and one long output hold-off.");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("utf16_utf32_to_utf8_transcoder_core verification clean");
		else
			$display("utf16_utf32_to_utf8_transcoder_core verification failed");
		$finish;
	end

endmodule
